// ===== rtl/i2c_timing_register_solver_macros.svh =====
// Assertion macros used by the timing solver controller.
// Expects signals named clk and rst in the scope of each use.
`ifndef I2C_TIMING_REGISTER_SOLVER_MACROS_SVH
`define I2C_TIMING_REGISTER_SOLVER_MACROS_SVH
`ifndef ASSERT_OFF
`define I2CTRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define I2CTRS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define I2CTRS_ASSERT(lbl, prop, msg)
`define I2CTRS_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/i2ctrs_pkg.sv =====
// Shared types, command codes and timing-class constants for the timing solver.
// No dependencies; imported by every module of the block.
package i2ctrs_pkg;

  localparam int NS_W   = 44;
  localparam int TCLK_W = 30;
  localparam int ERR_W  = 16;
  localparam int OP_W   = 5;

  localparam logic [1:0] CLS_NONE = 2'd3;

  localparam logic [OP_W-1:0] OP_NONE      = 5'd0;
  localparam logic [OP_W-1:0] OP_LOAD      = 5'd1;
  localparam logic [OP_W-1:0] OP_DIV       = 5'd2;
  localparam logic [OP_W-1:0] OP_MUL_DNF   = 5'd3;
  localparam logic [OP_W-1:0] OP_PREP_A    = 5'd4;
  localparam logic [OP_W-1:0] OP_PREP_B    = 5'd5;
  localparam logic [OP_W-1:0] OP_PREP_C    = 5'd6;
  localparam logic [OP_W-1:0] OP_S_NEXT    = 5'd7;
  localparam logic [OP_W-1:0] OP_D_NEXT    = 5'd8;
  localparam logic [OP_W-1:0] OP_RECORD    = 5'd9;
  localparam logic [OP_W-1:0] OP_P_NEXT    = 5'd10;
  localparam logic [OP_W-1:0] OP_SRCH_INIT = 5'd11;
  localparam logic [OP_W-1:0] OP_K_MUL     = 5'd12;
  localparam logic [OP_W-1:0] OP_LO_INIT   = 5'd13;
  localparam logic [OP_W-1:0] OP_LO_NEXT   = 5'd14;
  localparam logic [OP_W-1:0] OP_HI_INIT   = 5'd15;
  localparam logic [OP_W-1:0] OP_HI_STEP   = 5'd16;
  localparam logic [OP_W-1:0] OP_K_NEXT    = 5'd17;
  localparam logic [OP_W-1:0] OP_OUT       = 5'd18;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            rd_fin;
  } cmd_t;

  typedef struct packed {
    logic skip;
    logic div_busy;
    logic s_hit;
    logic s_last;
    logic d_hit;
    logic d_last;
    logic p_last;
    logic cand_last;
    logic cand_full;
    logic cand_empty;
    logic k_last;
    logic lo_ok;
    logic lo_last;
    logic hi_last;
  } sts_t;

  function automatic logic [1:0] cls_of(logic [23:0] f);
    logic [1:0] c;
    if (f >= 24'd80000 && f <= 24'd120000) c = 2'd0;
    else if (f >= 24'd320000 && f <= 24'd480000) c = 2'd1;
    else if (f >= 24'd800000 && f <= 24'd1200000) c = 2'd2;
    else c = CLS_NONE;
    return c;
  endfunction

  // Floor of the SDA delay window (fall + hold - analog filter), clipped at zero.
  function automatic logic [15:0] cls_sda_min(logic [1:0] c);
    logic [15:0] v;
    unique case (c)
      2'd1: v = 16'd50;
      2'd2: v = 16'd50;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

  // Ceiling of the SDA delay window (valid - rise - analog filter).
  function automatic logic [15:0] cls_sda_max(logic [1:0] c);
    logic [15:0] v;
    unique case (c)
      2'd0: v = 16'd2550;
      2'd1: v = 16'd390;
      default: v = 16'd130;
    endcase
    return v;
  endfunction

  function automatic logic [15:0] cls_scl_min(logic [1:0] c);
    logic [15:0] v;
    unique case (c)
      2'd0: v = 16'd890;
      2'd1: v = 16'd350;
      default: v = 16'd110;
    endcase
    return v;
  endfunction

  function automatic logic [15:0] cls_low_min(logic [1:0] c);
    logic [15:0] v;
    unique case (c)
      2'd0: v = 16'd4700;
      2'd1: v = 16'd1300;
      default: v = 16'd500;
    endcase
    return v;
  endfunction

  function automatic logic [15:0] cls_high_min(logic [1:0] c);
    logic [15:0] v;
    unique case (c)
      2'd0: v = 16'd4000;
      2'd1: v = 16'd600;
      default: v = 16'd260;
    endcase
    return v;
  endfunction

  function automatic logic [15:0] cls_rise_fall(logic [1:0] c);
    logic [15:0] v;
    unique case (c)
      2'd0: v = 16'd660;
      2'd1: v = 16'd350;
      default: v = 16'd160;
    endcase
    return v;
  endfunction

  function automatic logic [ERR_W-1:0] cls_nominal(logic [1:0] c);
    logic [ERR_W-1:0] v;
    unique case (c)
      2'd0: v = 16'd10000;
      2'd1: v = 16'd2500;
      default: v = 16'd1000;
    endcase
    return v;
  endfunction

  function automatic logic [15:0] cls_period_min(logic [1:0] c);
    logic [15:0] v;
    unique case (c)
      2'd0: v = 16'd8333;
      2'd1: v = 16'd2083;
      default: v = 16'd833;
    endcase
    return v;
  endfunction

  function automatic logic [15:0] cls_period_max(logic [1:0] c);
    logic [15:0] v;
    unique case (c)
      2'd0: v = 16'd12500;
      2'd1: v = 16'd3125;
      default: v = 16'd1250;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/i2c_timing_register_solver.sv =====
// Top level of the I2C timing register solver: ports, filter register,
// controller and datapath. Depends on i2ctrs_pkg, i2ctrs_ctrl and i2ctrs_dp.
//
//  Channel   Direction  Content (low bits first)
//  s_axis    in         tdata: source_clock_hz[29:0], bus_freq_hz[53:30], zeros
//  m_axis    out        tdata: timing_word; tuser: found[0], speed_class[2:1]
//  cfg       in         cfg_wr_data: digital_filter_coef, written when cfg_wr_en
//
// One word in gives one word out. A request runs a set-up that waits on the
// bit-serial period divider, then a delay scan for each prescaler, then for
// each recorded candidate a low/high level search, one trial per cycle in the
// shared compare datapath. Out-of-range bus frequencies and a zero kernel
// clock skip the delay scan and the level search.
// Reset is synchronous and clears the controller, the result and the filter
// register. A new word is taken while the previous result still waits; a stalled
// output only holds the finished next result back.
module i2c_timing_register_solver import i2ctrs_pkg::*; #(
  parameter int PRESC_STEPS     = 16,
  parameter int DELAY_STEPS     = 16,
  parameter int LEVEL_STEPS     = 256,
  parameter int CANDIDATE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data,     // digital_filter_coef
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,    // source_clock_hz, bus_freq_hz, zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,    // timing_word
  output logic [2:0]  m_axis_tuser     // found, speed_class
);

  cmd_t       cmd;
  sts_t       sts;
  logic [3:0] dnf;
  logic       found;
  logic [1:0] speed_class;

  // The user must change the filter length only while no request is in flight; the block does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      dnf <= '0;
    end else if (cfg_wr_en) begin
      dnf <= cfg_wr_data;
    end
  end

  i2ctrs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  i2ctrs_dp #(
    .PRESC_STEPS    (PRESC_STEPS),
    .DELAY_STEPS    (DELAY_STEPS),
    .LEVEL_STEPS    (LEVEL_STEPS),
    .CANDIDATE_DEPTH(CANDIDATE_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .dnf      (dnf),
    .in_clk_hz(s_axis_tdata[29:0]),
    .in_bus_hz(s_axis_tdata[53:30]),
    .res_word (m_axis_tdata),
    .res_found(found),
    .res_class(speed_class)
  );

  assign m_axis_tuser = {speed_class, found};

endmodule

// ===== rtl/i2ctrs_div.sv =====
// Restoring divider, one quotient bit per cycle, for the kernel period.
// Depends on i2ctrs_pkg for the period width.
module i2ctrs_div import i2ctrs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [30:0]       num,
  input  logic [TCLK_W-1:0] den,
  output logic              busy,
  output logic [TCLK_W-1:0] quot
);

  logic [TCLK_W-1:0] rem;
  logic [30:0]       numr;
  logic [4:0]        cnt;
  logic [TCLK_W:0]   trial;
  logic              take;

  assign trial = {rem, numr[30]};
  assign take  = trial >= {1'b0, den};
  assign quot  = numr[TCLK_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 5'd31;
      rem  <= '0;
      numr <= num;
    end else if (busy) begin
      rem  <= take ? TCLK_W'(trial - {1'b0, den}) : trial[TCLK_W-1:0];
      numr <= {numr[29:0], take};
      cnt  <= cnt - 5'd1;
      if (cnt == 5'd1) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/i2ctrs_ctrl.sv =====
// Sequencer of the timing solver: handshakes, candidate scan and level search.
// Depends on i2ctrs_pkg and the assertion macro header.
`include "i2c_timing_register_solver_macros.svh"
module i2ctrs_ctrl import i2ctrs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_CHECK   = 5'd1;
  localparam logic [4:0] S_DIV     = 5'd2;
  localparam logic [4:0] S_MUL     = 5'd3;
  localparam logic [4:0] S_PA      = 5'd4;
  localparam logic [4:0] S_PB      = 5'd5;
  localparam logic [4:0] S_PC      = 5'd6;
  localparam logic [4:0] S_SCAN_S  = 5'd7;
  localparam logic [4:0] S_SCAN_D  = 5'd8;
  localparam logic [4:0] S_P_ADV   = 5'd9;
  localparam logic [4:0] S_SRCH    = 5'd10;
  localparam logic [4:0] S_K_RD    = 5'd11;
  localparam logic [4:0] S_K_MUL   = 5'd12;
  localparam logic [4:0] S_LO_INIT = 5'd13;
  localparam logic [4:0] S_LO_CHK  = 5'd14;
  localparam logic [4:0] S_HI      = 5'd15;
  localparam logic [4:0] S_LO_ADV  = 5'd16;
  localparam logic [4:0] S_K_ADV   = 5'd17;
  localparam logic [4:0] S_FIN_RD  = 5'd18;
  localparam logic [4:0] S_DONE    = 5'd19;

  logic [4:0] state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    cmd.rd_fin = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.skip) begin
          state_next = S_DONE;
        end else begin
          cmd.op     = OP_DIV;
          state_next = S_DIV;
        end
      end
      S_DIV: if (!sts.div_busy) state_next = S_MUL;
      S_MUL: begin
        cmd.op     = OP_MUL_DNF;
        state_next = S_PA;
      end
      S_PA: begin
        cmd.op     = OP_PREP_A;
        state_next = S_PB;
      end
      S_PB: begin
        cmd.op     = OP_PREP_B;
        state_next = S_PC;
      end
      S_PC: begin
        cmd.op     = OP_PREP_C;
        state_next = S_SCAN_S;
      end
      S_SCAN_S: begin
        priority if (sts.s_hit) state_next = S_SCAN_D;
        else if (sts.s_last) state_next = S_P_ADV;
        else cmd.op = OP_S_NEXT;
      end
      S_SCAN_D: begin
        priority if (sts.d_hit) begin
          cmd.op     = OP_RECORD;
          state_next = sts.cand_last ? S_SRCH : S_P_ADV;
        end else if (sts.d_last) begin
          state_next = S_P_ADV;
        end else begin
          cmd.op = OP_D_NEXT;
        end
      end
      S_P_ADV: begin
        if (sts.p_last) begin
          state_next = S_SRCH;
        end else begin
          cmd.op     = OP_P_NEXT;
          state_next = S_SCAN_S;
        end
      end
      S_SRCH: begin
        if (sts.cand_empty) begin
          state_next = S_DONE;
        end else begin
          cmd.op     = OP_SRCH_INIT;
          state_next = S_K_RD;
        end
      end
      S_K_RD: state_next = S_K_MUL;
      S_K_MUL: begin
        cmd.op     = OP_K_MUL;
        state_next = S_LO_INIT;
      end
      S_LO_INIT: begin
        cmd.op     = OP_LO_INIT;
        state_next = S_LO_CHK;
      end
      S_LO_CHK: begin
        if (sts.lo_ok) begin
          cmd.op     = OP_HI_INIT;
          state_next = S_HI;
        end else begin
          state_next = S_LO_ADV;
        end
      end
      S_HI: begin
        cmd.op = OP_HI_STEP;
        if (sts.hi_last) state_next = S_LO_ADV;
      end
      S_LO_ADV: begin
        if (sts.lo_last) begin
          state_next = S_K_ADV;
        end else begin
          cmd.op     = OP_LO_NEXT;
          state_next = S_LO_CHK;
        end
      end
      S_K_ADV: begin
        if (sts.k_last) begin
          state_next = S_FIN_RD;
        end else begin
          cmd.op     = OP_K_NEXT;
          state_next = S_K_RD;
        end
      end
      S_FIN_RD: begin
        cmd.rd_fin = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        cmd.rd_fin = 1'b1;
        if (!out_valid || out_ready) begin
          cmd.op     = OP_OUT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.op == OP_OUT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `I2CTRS_ASSERT_IMPL(a_no_overfill, cmd.op == OP_RECORD, !sts.cand_full, "candidate overflow")
  `I2CTRS_ASSERT_IMPL(a_out_free, cmd.op == OP_OUT, !out_valid || out_ready, "result overwritten")
  `I2CTRS_ASSERT_IMPL(a_search_has_cand, cmd.op == OP_K_MUL, !sts.cand_empty, "search with no candidate")

endmodule

// ===== rtl/i2ctrs_dp.sv =====
// Datapath of the timing solver: period divide, delay scan, candidate memory,
// level search with a two-stage error pipeline. Depends on i2ctrs_pkg, i2ctrs_div.
module i2ctrs_dp import i2ctrs_pkg::*; #(
  parameter int PRESC_STEPS     = 16,
  parameter int DELAY_STEPS     = 16,
  parameter int LEVEL_STEPS     = 256,
  parameter int CANDIDATE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic [3:0]  dnf,
  input  logic [29:0] in_clk_hz,
  input  logic [23:0] in_bus_hz,
  output logic [31:0] res_word,
  output logic        res_found,
  output logic [1:0]  res_class
);

  localparam int PW = $clog2(PRESC_STEPS + 1);
  localparam int SW = $clog2(DELAY_STEPS + 1);
  localparam int LW = $clog2(LEVEL_STEPS + 1);
  localparam int CW = $clog2(CANDIDATE_DEPTH + 1);
  localparam int AW = (CANDIDATE_DEPTH > 1) ? $clog2(CANDIDATE_DEPTH) : 1;

  logic [29:0]       clk_hz;
  logic [1:0]        cls;
  logic [TCLK_W-1:0] tclk;
  logic              div_busy;

  logic [NS_W-1:0] filt_ns, d3, d4, base, sda_lo, sda_hi;
  logic [NS_W-1:0] tp, st, dt, tpresc, t_low, q, t_high, tlrf;
  logic [PW-1:0]   p;
  logic [SW-1:0]   s, d;
  logic [LW-1:0]   lo, hi;
  logic [CW-1:0]   count, k;
  logic [11:0]     cand_mem [CANDIDATE_DEPTH];
  logic [11:0]     rd_data;
  logic [AW-1:0]   rd_addr;
  logic [AW-1:0]   best_index;
  logic [15:0]     best_hl;
  logic [ERR_W-1:0] best_err;
  logic            hit;

  logic [33:0]     dnf_prod;
  logic [34:0]     presc_prod;
  logic [NS_W-1:0] period;
  logic            period_ok;

  logic            p1_valid;
  logic [ERR_W-1:0] p1_period;
  logic [LW-1:0]   p1_lo, p1_hi;
  logic [CW-1:0]   p1_k;
  logic [ERR_W-1:0] err;

  i2ctrs_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.op == OP_DIV),
    .num  (31'd1000000000 + 31'(clk_hz >> 1)),
    .den  (clk_hz),
    .busy (div_busy),
    .quot (tclk)
  );

  assign dnf_prod   = 34'(dnf) * 34'(tclk);
  assign presc_prod = 35'(rd_data[11:8] + 5'd1) * 35'(tclk);

  assign period    = tlrf + t_high;
  assign period_ok = period >= NS_W'(cls_period_min(cls)) &&
                     period <= NS_W'(cls_period_max(cls)) &&
                     t_high >= NS_W'(cls_high_min(cls)) && t_high > NS_W'(tclk);

  // Qualified periods never exceed the class maximum, so the error is narrow.
  assign err = (p1_period >= cls_nominal(cls)) ? p1_period - cls_nominal(cls)
                                               : cls_nominal(cls) - p1_period;

  assign rd_addr = cmd.rd_fin ? best_index : k[AW-1:0];

  always_comb begin
    sts.skip       = (cls == CLS_NONE) || (clk_hz == '0);
    sts.div_busy   = div_busy;
    sts.s_hit      = st >= NS_W'(cls_scl_min(cls));
    sts.s_last     = (s == SW'(DELAY_STEPS - 1));
    sts.d_hit      = (dt >= sda_lo) && (dt <= sda_hi);
    sts.d_last     = (d == SW'(DELAY_STEPS - 1));
    sts.p_last     = (p == PW'(PRESC_STEPS - 1));
    sts.cand_last  = (count == CW'(CANDIDATE_DEPTH - 1));
    sts.cand_full  = (count == CW'(CANDIDATE_DEPTH));
    sts.cand_empty = (count == '0);
    sts.k_last     = (k == count - CW'(1));
    sts.lo_ok      = (t_low > NS_W'(cls_low_min(cls))) && ((q >> 2) > NS_W'(tclk));
    sts.lo_last    = (lo == LW'(LEVEL_STEPS - 1));
    sts.hi_last    = (hi == LW'(LEVEL_STEPS - 1));
  end

  always_ff @(posedge clk) begin
    rd_data <= cand_mem[rd_addr];
    if (cmd.op == OP_RECORD) begin
      cand_mem[count[AW-1:0]] <= {4'(p), 4'(s), 4'(d)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      hit        <= 1'b0;
      best_err   <= '0;
      best_index <= '0;
      best_hl    <= '0;
      p1_valid   <= 1'b0;
      cls        <= CLS_NONE;
      clk_hz     <= '0;
      res_word   <= '0;
      res_found  <= 1'b0;
      res_class  <= CLS_NONE;
    end else begin
      p1_valid <= (cmd.op == OP_HI_STEP) && period_ok;
      if (p1_valid && err < best_err) begin
        best_err   <= err;
        best_index <= p1_k[AW-1:0];
        best_hl    <= {8'(p1_hi), 8'(p1_lo)};
        hit        <= 1'b1;
      end
      unique case (cmd.op)
        OP_LOAD: begin
          clk_hz <= in_clk_hz;
          cls    <= cls_of(in_bus_hz);
          count  <= '0;
          hit    <= 1'b0;
        end
        OP_MUL_DNF: begin
          filt_ns <= NS_W'(dnf_prod);
          p  <= '0;
          s  <= '0;
          d  <= '0;
          tp <= NS_W'(tclk);
          st <= NS_W'(tclk);
          dt <= '0;
        end
        OP_PREP_A: begin
          d3   <= filt_ns + NS_W'(tclk) + (NS_W'(tclk) << 1);
          base <= NS_W'(50) + filt_ns + (NS_W'(tclk) << 1);
        end
        OP_PREP_B: begin
          sda_lo <= (d3 < NS_W'(cls_sda_min(cls))) ? NS_W'(cls_sda_min(cls)) - d3 : '0;
          d4     <= d3 + NS_W'(tclk);
        end
        OP_PREP_C: begin
          sda_hi <= (d4 < NS_W'(cls_sda_max(cls))) ? NS_W'(cls_sda_max(cls)) - d4 : '0;
        end
        OP_S_NEXT: begin
          s  <= s + SW'(1);
          st <= st + tp;
        end
        OP_D_NEXT: begin
          d  <= d + SW'(1);
          dt <= dt + tp;
        end
        OP_RECORD: count <= count + CW'(1);
        OP_P_NEXT: begin
          p  <= p + PW'(1);
          tp <= tp + NS_W'(tclk);
          st <= tp + NS_W'(tclk);
          s  <= '0;
          d  <= '0;
          dt <= '0;
        end
        OP_SRCH_INIT: begin
          k        <= '0;
          best_err <= cls_nominal(cls);
        end
        OP_K_MUL: tpresc <= NS_W'(presc_prod);
        OP_LO_INIT: begin
          lo    <= '0;
          t_low <= base + tpresc;
          q     <= (NS_W'(tclk) << 1) + tpresc;
        end
        OP_LO_NEXT: begin
          lo    <= lo + LW'(1);
          t_low <= t_low + tpresc;
          q     <= q + tpresc;
        end
        OP_HI_INIT: begin
          hi     <= '0;
          t_high <= base + tpresc;
          tlrf   <= t_low + NS_W'(cls_rise_fall(cls));
        end
        OP_HI_STEP: begin
          p1_period <= period[ERR_W-1:0];
          p1_lo     <= lo;
          p1_hi     <= hi;
          p1_k      <= k;
          hi        <= hi + LW'(1);
          t_high    <= t_high + tpresc;
        end
        OP_K_NEXT: k <= k + CW'(1);
        OP_OUT: begin
          res_word  <= hit ? {rd_data[11:8], 4'b0000, rd_data[7:4], rd_data[3:0], best_hl}
                           : 32'd0;
          res_found <= hit;
          res_class <= cls;
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== sim/tb_i2c_timing_checker.sv =====
// Checker for the I2C timing register solver: predicts each result word
// from the accepted request words and compares it with the output stream.
// Depends on i2ctrs_pkg for the out-of-range class code.
module tb_i2c_timing_checker import i2ctrs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,
  input  logic [2:0]  m_axis_tuser,
  output int          error_count,
  output int          pending_words
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] timing_word;
    logic        found;
    logic [1:0]  speed_class;
  } timing_result_t;

  // Class limits (frequencies in hertz, times in nanoseconds): standard, fast, fast plus. Hold minimum is zero.
  localparam longint unsigned NOMINAL_HZ[3] = '{100000, 400000, 1000000};
  localparam longint unsigned FMIN_HZ[3]    = '{80000, 320000, 800000};
  localparam longint unsigned FMAX_HZ[3]    = '{120000, 480000, 1200000};
  localparam longint unsigned VALID_MAX[3]  = '{3450, 900, 450};
  localparam longint unsigned SETUP_MIN[3]  = '{250, 100, 50};
  localparam longint unsigned LOW_MIN[3]    = '{4700, 1300, 500};
  localparam longint unsigned HIGH_MIN[3]   = '{4000, 600, 260};
  localparam longint unsigned RISE_NS[3]    = '{640, 250, 60};
  localparam longint unsigned FALL_NS[3]    = '{20, 100, 100};
  localparam longint unsigned AF_MIN = 50;
  localparam longint unsigned AF_MAX = 260;

  logic [3:0]     filter_coef;
  timing_result_t expected_results[$];

  function automatic timing_result_t solve_timing(input logic [3:0] dnf_coef,
                                                  input logic [29:0] kernel_hz,
                                                  input logic [23:0] bus_hz);
    timing_result_t  res;
    int              c;
    longint unsigned tclk, dnf, lo_lim, hi_lim, scl_min, t, tpresc;
    longint unsigned filt_ns, nominal, pmax, pmin, base, t_low, t_high, period, err;
    longint unsigned best_err;
    longint          sda_min, sda_max;
    int              cand_p[16], cand_s[16], cand_d[16];
    int              n_cand, best_k, best_lo, best_hi;
    bit              taken, full, hit;

    res = '0;
    res.speed_class = CLS_NONE;
    c = -1;
    for (int i = 2; i >= 0; i--)
      if (bus_hz >= FMIN_HZ[i] && bus_hz <= FMAX_HZ[i]) c = i;
    if (c >= 0) res.speed_class = 2'(c);
    if (c < 0 || kernel_hz == 0) return res;

    tclk = (64'd1000000000 + kernel_hz / 2) / kernel_hz;
    dnf  = 64'(dnf_coef);

    // Delay scan: first SCL/SDA delay pair per prescaler, at most 16 entries.
    sda_min = longint'(FALL_NS[c]) - longint'(AF_MIN) - longint'((dnf + 3) * tclk);
    sda_max = longint'(VALID_MAX[c]) - longint'(RISE_NS[c]) - longint'(AF_MAX)
              - longint'((dnf + 4) * tclk);
    lo_lim  = sda_min > 0 ? longint'(sda_min) : 0;
    hi_lim  = sda_max > 0 ? longint'(sda_max) : 0;
    scl_min = RISE_NS[c] + SETUP_MIN[c];
    n_cand  = 0;
    full    = 0;
    for (int p = 0; p < 16 && !full; p++) begin
      taken = 0;
      for (int s = 0; s < 16 && !taken; s++) begin
        if (longint'(s + 1) * (p + 1) * tclk < scl_min) continue;
        for (int d = 0; d < 16 && !taken; d++) begin
          t = longint'(d) * (p + 1) * tclk;
          if (t >= lo_lim && t <= hi_lim) begin
            cand_p[n_cand] = p;
            cand_s[n_cand] = s;
            cand_d[n_cand] = d;
            n_cand++;
            taken = 1;
            if (n_cand >= 16) full = 1;
          end
        end
      end
    end

    // Level search: smallest period error; the first one found wins a tie.
    filt_ns   = dnf * tclk;
    nominal   = (64'd1000000000 + NOMINAL_HZ[c] / 2) / NOMINAL_HZ[c];
    pmax      = 64'd1000000000 / FMIN_HZ[c];
    pmin      = 64'd1000000000 / FMAX_HZ[c];
    base      = AF_MIN + filt_ns + 2 * tclk;
    best_err  = nominal;
    hit       = 0;
    best_k    = 0;
    best_lo   = 0;
    best_hi   = 0;
    for (int k = 0; k < n_cand; k++) begin
      tpresc = longint'(cand_p[k] + 1) * tclk;
      for (int lo = 0; lo < 256; lo++) begin
        t_low = base + longint'(lo + 1) * tpresc;
        if (!(t_low > LOW_MIN[c] && tclk < (t_low - AF_MIN - filt_ns) / 4)) continue;
        for (int hi = 0; hi < 256; hi++) begin
          t_high = base + longint'(hi + 1) * tpresc;
          period = t_low + t_high + RISE_NS[c] + FALL_NS[c];
          if (period < pmin || period > pmax || t_high < HIGH_MIN[c] || tclk >= t_high)
            continue;
          err = period >= nominal ? period - nominal : nominal - period;
          if (err < best_err) begin
            best_err = err;
            best_k   = k;
            best_lo  = lo;
            best_hi  = hi;
            hit      = 1;
          end
        end
      end
    end
    if (hit) begin
      res.timing_word = {4'(cand_p[best_k]), 4'd0, 4'(cand_s[best_k]),
                         4'(cand_d[best_k]), 8'(best_hi), 8'(best_lo)};
      res.found = 1'b1;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: mismatch in %s: got 0x%08h, expected 0x%08h", $time, what, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin
    timing_result_t want;
    if (rst) begin
      filter_coef = '0;
      expected_results.delete();
      error_count = 0;
      pending_words <= 0;
    end else begin
      if (cfg_wr_en) filter_coef = cfg_wr_data;
      // The output side is checked first so that a word accepted in the same
      // cycle can never be matched against its own expectation.
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected word", m_axis_tdata, 32'd0);
        end else begin
          want = expected_results.pop_front();
          if (m_axis_tdata !== want.timing_word)
            report_mismatch("timing_word", m_axis_tdata, want.timing_word);
          if (m_axis_tuser[0] !== want.found)
            report_mismatch("found", 32'(m_axis_tuser[0]), 32'(want.found));
          if (m_axis_tuser[2:1] !== want.speed_class)
            report_mismatch("speed_class", 32'(m_axis_tuser[2:1]), 32'(want.speed_class));
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_results.push_back(solve_timing(filter_coef, s_axis_tdata[29:0],
                                                s_axis_tdata[53:30]));
      pending_words <= expected_results.size();
    end
  end

endmodule

// ===== sim/tb_top.sv =====
// Top of the I2C timing register solver testbench: clock, reset, request
// stimulus, result back-pressure and the verdict. Depends on i2ctrs_pkg,
// the solver RTL and tb_i2c_timing_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [3:0]  cfg_wr_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata;   // source_clock_hz[29:0], bus_freq_hz[53:30], zero pad
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // timing_word
  logic [2:0]  m_axis_tuser;   // found[0], speed_class[2:1]

  int error_count;
  int pending_words;

  // Idling switches: sender and receiver gaps, and one long receiver hold-off.
  bit send_idles;
  bit recv_idles;
  bit holdoff_req;
  bit holdoff_done;
  int holdoff_left;

  i2c_timing_register_solver u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  tb_i2c_timing_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .error_count   (error_count),
    .pending_words (pending_words)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // A full solve runs the whole delay scan and level search, and only a couple of
  // dozen requests fall in a class with a running kernel clock, so this bound
  // leaves several times the slowest correct run.
  initial begin
    #400000000;
    $display("Simulation FAILED");
    $finish;
  end

  // Receiver: random stalls, except when idling is off; one long hold-off on
  // request, counted here so the sender keeps pushing words meanwhile.
  initial begin
    m_axis_tready = 1'b0;
    holdoff_done  = 1'b0;
    holdoff_left  = 0;
    forever begin
      @(posedge clk);
      if (holdoff_left > 0) begin
        holdoff_left--;
        m_axis_tready <= 1'b0;
      end else if (holdoff_req && !holdoff_done) begin
        holdoff_done = 1'b1;
        holdoff_left = 3000;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= !(recv_idles && $urandom_range(99) < 8);
      end
    end
  end

  // Offers one request word and waits for it to be taken. A random gap may
  // precede it; valid stays high between back-to-back words.
  task automatic send_request(input logic [29:0] kernel_hz, input logic [23:0] bus_hz);
    if (send_idles && $urandom_range(99) < 8) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, bus_hz, kernel_hz};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
  endtask

  // Filter register writes happen only with nothing in flight.
  task automatic write_filter(input logic [3:0] coef);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= coef;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // A request that skips the search: bus frequency outside every class, or
  // a stopped kernel clock with any bus frequency.
  task automatic send_quick();
    logic [23:0] bus_hz;
    if ($urandom_range(1)) begin
      case ($urandom_range(3))
        0: bus_hz = 24'($urandom_range(79999));
        1: bus_hz = 24'($urandom_range(319999, 120001));
        2: bus_hz = 24'($urandom_range(799999, 480001));
        default: bus_hz = 24'($urandom_range(24'hFFFFFF, 1200001));
      endcase
      send_request(30'($urandom), bus_hz);
    end else begin
      send_request(30'd0, 24'($urandom));
    end
  endtask

  // A request inside one of the class windows with a running kernel clock;
  // these run the full delay scan and level search.
  task automatic send_solve();
    logic [29:0] kernel_hz;
    logic [23:0] bus_hz;
    case ($urandom_range(2))
      0: bus_hz = 24'($urandom_range(120000, 80000));
      1: bus_hz = 24'($urandom_range(480000, 320000));
      default: bus_hz = 24'($urandom_range(1200000, 800000));
    endcase
    case ($urandom_range(3))
      0: kernel_hz = 30'($urandom_range(1000000000, 1));
      1: kernel_hz = 30'($urandom_range(200000000, 4000000));
      2: kernel_hz = 30'($urandom_range(4000000, 1));
      default: kernel_hz = 30'($urandom) | 30'h1;
    endcase
    send_request(kernel_hz, bus_hz);
  endtask

  initial begin
    rst           = 1'b1;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = 4'd0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    send_idles    = 1'b1;
    recv_idles    = 1'b1;
    holdoff_req   = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part with the filter off: edges of every class window, a
    // stopped and a maximal kernel clock, and bus frequencies outside all
    // classes, including zero and the all-ones value.
    write_filter(4'd0);
    send_request(30'd0, 24'd100000);
    send_request(30'd0, 24'hFFFFFF);
    send_request(30'd100000000, 24'd0);
    send_request(30'd100000000, 24'd79999);
    send_request(30'd100000000, 24'd120001);
    send_request(30'h3FFFFFFF, 24'd500000);
    send_request(30'd100000000, 24'hFFFFFF);
    send_request(30'd100000000, 24'd80000);
    send_request(30'd100000000, 24'd120000);
    send_request(30'd48000000, 24'd320000);
    send_request(30'h3FFFFFFF, 24'd480000);
    send_request(30'd1, 24'd1000000);
    send_request(30'd64000000, 24'd800000);
    send_request(30'd100000000, 24'd1200000);

    // Longest filter.
    write_filter(4'd15);
    send_request(30'd100000000, 24'd100000);
    send_request(30'd8000000, 24'd1000000);
    send_request(30'd1000000000, 24'd400000);

    // Back-pressure: the receiver holds off while cheap words keep coming,
    // so the block fills and stalls its input.
    write_filter(4'd15);
    holdoff_req = 1'b1;
    repeat (12) send_quick();

    // Random phases, each with its own filter setting; one phase with no
    // idling at all on either side.
    for (int phase = 0; phase < 4; phase++) begin
      write_filter(phase == 0 ? 4'd0 : phase == 3 ? 4'd15 : 4'($urandom));
      send_idles = (phase != 2);
      recv_idles = (phase != 2);
      for (int n = 0; n < 20; n++) begin
        if ($urandom_range(99) < 12) send_solve();
        else send_quick();
        // Midway through each phase the sender pauses until every result is back.
        if (n == 10) wait_drained();
      end
    end

    wait_drained();
    repeat (50) @(posedge clk);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
